### src/kronecker_product_element_assert.svh
// Assertion macros used by the checker module of the Kronecker product block.
// Every macro samples on clock and is disabled while reset is high.
`ifndef KRONECKER_PRODUCT_ELEMENT_ASSERT_SVH
`define KRONECKER_PRODUCT_ELEMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/kpe_pkg.sv
// Package of the Kronecker product block: widths, payload types, codes and
// small helper functions. It depends on nothing else.
package kpe_pkg;

   localparam int MAX_DIM     = 16;
   localparam int ELEM_BITS   = 16;
   localparam int DIM_W       = 5;
   localparam int ROW_W       = 8;
   localparam int VALUE_W     = 16;
   localparam int PRODUCT_W   = 32;
   localparam int KIND_W      = 2;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LIM_W       = 2 * DIM_W;
   localparam int DIV_STEPS   = 2;
   localparam int DSH_W       = DIM_W + IDX_W - 1;
   localparam int DIV_W       = (ROW_W > DSH_W) ? ROW_W : DSH_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE_A = 2'd0,
      KIND_WRITE_B = 2'd1,
      KIND_READ    = 2'd2
   } kpe_kind_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_COLS_A = 2'd1,
      CSR_ROWS_B = 2'd2,
      CSR_COLS_B = 2'd3
   } kpe_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_HOLD
   } kpe_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [ROW_W-1:0]          row;
      logic [ROW_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } kpe_req_type;

   typedef struct packed {
      logic signed [PRODUCT_W-1:0] product;
      logic                        status;
   } kpe_rsp_type;

   // A dimension of zero acts as one, anything above MAX_DIM as MAX_DIM.
   function automatic logic [DIM_W-1:0] kpe_eff_dim(input logic [DIM_W-1:0] raw);
      logic [DIM_W-1:0] dim;
      dim = raw;
      if (raw == '0) begin
         dim = DIM_W'(1);
      end else if (int'(raw) > MAX_DIM) begin
         dim = DIM_W'(MAX_DIM);
      end
      return dim;
   endfunction

   function automatic logic [ADDR_W-1:0] kpe_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
   endfunction

endpackage

### src/kronecker_product_element.sv
// Top level of the Kronecker product block: configuration registers, control
// sequencer, the two element stores and the multiplier. Uses kpe_pkg, kpe_ram, kpe_div.
//
// Usage:
// - csr_*: writes one dimension register (rows_a, cols_a, rows_b, cols_b) per
//   transfer; always ready. Write them only while no item is in flight.
// - req_*: one item per transfer. Kind 0 or 1 stores an element of A or B,
//   kind 2 reads element (row, col) of the Kronecker product A x B.
// - rsp_*: exactly one result per item, in order: a Q16.16 product and a
//   status bit (1 for an index outside the configured dimensions or kind 3).
// Sequence: a write or a rejected item is registered at its transfer and moves to
//   the output register in ST_HOLD; the next item is taken once the sequencer is
//   back in ST_IDLE. A product read first passes the two-lane divider that splits
//   the indexes (ST_DIV), then the store read and the multiplier (ST_MUL), and then
//   the result register and the output register (ST_HOLD).
// Only one item is worked on at a time; req_ready is high while the sequencer
//   is idle, even while a finished result still waits in the output register.
// If the receiver stalls, the result stays in the output register and the
//   next item stops at its last step until that register is free.
// Reset sets all dimensions to one and empties the pipeline; the stores are not
//   cleared, so each element must be written before it is read.
module kronecker_product_element (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kpe_pkg::kpe_req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kpe_pkg::kpe_rsp_type     rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  kpe_pkg::kpe_csr_type     csr_index,
   input  logic [kpe_pkg::DIM_W-1:0] csr_wdata
);
   import kpe_pkg::*;

   kpe_state_type state_ff, state_in;

   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] cols_a_ff, cols_a_in;
   logic [DIM_W-1:0] rows_b_ff, rows_b_in;
   logic [DIM_W-1:0] cols_b_ff, cols_b_in;

   kpe_rsp_type res_ff, res_in;
   kpe_rsp_type rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic req_accept, csr_accept, rsp_free;
   logic item_ok, is_read;
   logic [LIM_W-1:0] lim_rows, lim_cols, row_ext, col_ext;
   logic wr_a_ok, wr_b_ok, rd_ok;

   logic div_start, wr_a_en, wr_b_en, load_rsp;
   logic row_done, col_done;
   logic [IDX_W-1:0] row_quo, row_rem, col_quo, col_rem;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [ELEM_BITS-1:0] a_rdata, b_rdata;
   logic signed [2*ELEM_BITS-1:0] mul_full;

   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Range checks of the incoming item.
   assign row_ext  = LIM_W'(req_data.row);
   assign col_ext  = LIM_W'(req_data.col);
   assign lim_rows = LIM_W'(rows_a_ff) * LIM_W'(rows_b_ff);
   assign lim_cols = LIM_W'(cols_a_ff) * LIM_W'(cols_b_ff);
   assign wr_a_ok  = (row_ext < LIM_W'(rows_a_ff)) && (col_ext < LIM_W'(cols_a_ff));
   assign wr_b_ok  = (row_ext < LIM_W'(rows_b_ff)) && (col_ext < LIM_W'(cols_b_ff));
   assign rd_ok    = (row_ext < lim_rows) && (col_ext < lim_cols);
   assign is_read  = (req_data.kind == KIND_READ);

   always_comb begin
      unique case (req_data.kind)
         KIND_WRITE_A: item_ok = wr_a_ok;
         KIND_WRITE_B: item_ok = wr_b_ok;
         KIND_READ:    item_ok = rd_ok;
         default:      item_ok = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (is_read && item_ok) ? ST_DIV : ST_HOLD;
            end
         end
         ST_DIV: begin
            if (row_done && col_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_HOLD;
         ST_HOLD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      wr_a_en   = 1'b0;
      wr_b_en   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_accept && is_read && item_ok;
            wr_a_en   = req_accept && (req_data.kind == KIND_WRITE_A) && item_ok;
            wr_b_en   = req_accept && (req_data.kind == KIND_WRITE_B) && item_ok;
         end
         ST_HOLD: load_rsp = rsp_free;
         default: ;
      endcase
   end

   // Dimension registers hold the effective (clamped) values.
   always_comb begin
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      rows_b_in = rows_b_ff;
      cols_b_in = cols_b_ff;
      if (csr_accept) begin
         unique case (csr_index)
            CSR_ROWS_A: rows_a_in = kpe_eff_dim(csr_wdata);
            CSR_COLS_A: cols_a_in = kpe_eff_dim(csr_wdata);
            CSR_ROWS_B: rows_b_in = kpe_eff_dim(csr_wdata);
            CSR_COLS_B: cols_b_in = kpe_eff_dim(csr_wdata);
         endcase
      end
   end

   kpe_div u_row_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_data.row),
      .divisor   (rows_b_ff),
      .done      (row_done),
      .quotient  (row_quo),
      .remainder (row_rem)
   );

   kpe_div u_col_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_data.col),
      .divisor   (cols_b_ff),
      .done      (col_done),
      .quotient  (col_quo),
      .remainder (col_rem)
   );

   // The store reads follow the divider outputs, so the data is there in ST_MUL.
   assign wr_addr   = kpe_addr(req_data.row[IDX_W-1:0], req_data.col[IDX_W-1:0]);
   assign rd_addr_a = kpe_addr(row_quo, col_quo);
   assign rd_addr_b = kpe_addr(row_rem, col_rem);

   kpe_ram #(.WIDTH(ELEM_BITS), .DEPTH(STORE_DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value[ELEM_BITS-1:0]),
      .rd_addr (rd_addr_a),
      .rd_data (a_rdata)
   );

   kpe_ram #(.WIDTH(ELEM_BITS), .DEPTH(STORE_DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value[ELEM_BITS-1:0]),
      .rd_addr (rd_addr_b),
      .rd_data (b_rdata)
   );

   assign mul_full = $signed(a_rdata) * $signed(b_rdata);

   always_comb begin
      res_in = res_ff;
      if (state_ff == ST_IDLE && req_accept) begin
         res_in.product = '0;
         res_in.status  = !item_ok;
      end else if (state_ff == ST_MUL) begin
         res_in.product = PRODUCT_W'(mul_full);
         res_in.status  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_a_ff    <= DIM_W'(1);
         cols_a_ff    <= DIM_W'(1);
         rows_b_ff    <= DIM_W'(1);
         cols_b_ff    <= DIM_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_a_ff    <= rows_a_in;
         cols_a_ff    <= cols_a_in;
         rows_b_ff    <= rows_b_in;
         cols_b_ff    <= cols_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/kpe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module kpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/kpe_div.sv
// Small restoring divider: an index divided by a configured dimension,
// DIV_STEPS quotient bits per cycle. Depends on kpe_pkg.
module kpe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [kpe_pkg::ROW_W-1:0]  dividend,
   input  logic [kpe_pkg::DIM_W-1:0]  divisor,
   output logic                       done,
   output logic [kpe_pkg::IDX_W-1:0]  quotient,
   output logic [kpe_pkg::IDX_W-1:0]  remainder
);
   import kpe_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [IDX_W-1:0] qbit_ff, qbit_in;
   logic [IDX_W-1:0] quo_ff, quo_in;

   // The caller guarantees the quotient fits in IDX_W bits, so the search
   // starts with the divisor shifted to the top quotient bit.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      qbit_in = qbit_ff;
      quo_in  = quo_ff;
      if (start) begin
         rem_in  = DIV_W'(dividend);
         dsh_in  = DIV_W'(divisor) << (IDX_W - 1);
         qbit_in = IDX_W'(1) << (IDX_W - 1);
         quo_in  = '0;
      end else begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            if (qbit_in != '0) begin
               if (rem_in >= dsh_in) begin
                  rem_in = rem_in - dsh_in;
                  quo_in = quo_in | qbit_in;
               end
               dsh_in  = dsh_in >> 1;
               qbit_in = qbit_in >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qbit_ff <= '0;
      end else begin
         qbit_ff <= qbit_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign done      = (qbit_ff == '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff[IDX_W-1:0];

endmodule

### src/kpe_checker.sv
// Port-level checker for the Kronecker product block, bound to the top level.
// Uses kpe_pkg types and the macros of kronecker_product_element_assert.svh.
`include "kronecker_product_element_assert.svh"

module kpe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input kpe_pkg::kpe_rsp_type      rsp_data
);

   // A stalled result must stay put.
   `KPE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Errors never carry a product.
   `KPE_ASSERT_SAME(a_err_zero, rsp_valid && rsp_data.status, rsp_data.product == '0, "error result with nonzero product")

   // Only one item is in flight: the block is busy right after a transfer.
   `KPE_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item taken while busy")

   // A new result appears only at the end of an item, never from the idle state.
   `KPE_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready), "result appeared while idle")

endmodule

bind kronecker_product_element kpe_checker u_kpe_checker (.*);

### bench/tb_kronecker_product_element.sv
// Self-checking testbench for the Kronecker product element block.
// Depends on kpe_pkg and kronecker_product_element; predicts each result in place or
// takes it from the directed table, and checks it on the valid/ready channels.
`timescale 1ns / 1ps

module tb_kronecker_product_element;
   import kpe_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED      = 2'd3;
   localparam logic              STATUS_OK        = 1'b0;
   localparam logic              STATUS_RANGE_ERR = 1'b1;
   localparam int DIRECTED_COUNT   = 22;
   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 135;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 20;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ROW_W-1:0]     row;
      logic [ROW_W-1:0]     col;
      logic [VALUE_W-1:0]   value;
      logic                 typed;
      logic [PRODUCT_W-1:0] product;
      logic                 status;
   } directed_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   kpe_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   kpe_rsp_type         rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   kpe_csr_type         csr_index = CSR_ROWS_A;
   logic [DIM_W-1:0]    csr_wdata = '0;

   // Local copy of the raw dimension values and of the block's element stores.
   logic [DIM_W-1:0]          rows_a_raw = 5'd1;
   logic [DIM_W-1:0]          cols_a_raw = 5'd1;
   logic [DIM_W-1:0]          rows_b_raw = 5'd1;
   logic [DIM_W-1:0]          cols_b_raw = 5'd1;
   logic signed [VALUE_W-1:0] a_elements [STORE_DEPTH];
   logic signed [VALUE_W-1:0] b_elements [STORE_DEPTH];
   bit                        a_written  [STORE_DEPTH];
   bit                        b_written  [STORE_DEPTH];

   kpe_rsp_type      expected_elements [$];
   int unsigned      mismatch_count = 0;
   bit               no_idle = 1'b0;
   directed_row_type directed_rows [DIRECTED_COUNT];

   kronecker_product_element dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned effective_dim(input logic [DIM_W-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(raw);
   endfunction

   function automatic void set_dim(input kpe_csr_type idx, input logic [DIM_W-1:0] v);
      case (idx)
         CSR_ROWS_A: rows_a_raw = v;
         CSR_COLS_A: cols_a_raw = v;
         CSR_ROWS_B: rows_b_raw = v;
         CSR_COLS_B: cols_b_raw = v;
         default: ;
      endcase
   endfunction

   // Computes the result of one item and updates the local stores.
   function automatic kpe_rsp_type predict_element(input kpe_req_type it);
      kpe_rsp_type r;
      int unsigned ra, ca, rb, cb, nr, nc, a_addr, b_addr;
      ra = effective_dim(rows_a_raw);
      ca = effective_dim(cols_a_raw);
      rb = effective_dim(rows_b_raw);
      cb = effective_dim(cols_b_raw);
      r.product = '0;
      r.status  = STATUS_RANGE_ERR;
      case (it.kind)
         KIND_WRITE_A, KIND_WRITE_B: begin
            nr = (it.kind == KIND_WRITE_A) ? ra : rb;
            nc = (it.kind == KIND_WRITE_A) ? ca : cb;
            if (it.row < nr && it.col < nc) begin
               a_addr = it.row * MAX_DIM + it.col;
               if (it.kind == KIND_WRITE_A) begin
                  a_elements[a_addr] = it.value;
                  a_written[a_addr]  = 1'b1;
               end else begin
                  b_elements[a_addr] = it.value;
                  b_written[a_addr]  = 1'b1;
               end
               r.status = STATUS_OK;
            end
         end
         KIND_READ: begin
            if (it.row < ra * rb && it.col < ca * cb) begin
               a_addr    = (it.row / rb) * MAX_DIM + it.col / cb;
               b_addr    = (it.row % rb) * MAX_DIM + it.col % cb;
               r.product = a_elements[a_addr] * b_elements[b_addr];
               r.status  = STATUS_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(1, 3);
      end
      if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // A product read that would touch a never-written element is turned into
   // the write of that element, so the read can follow later.
   function automatic kpe_req_type fill_before_read(input kpe_req_type it);
      int unsigned ra, ca, rb, cb, ar, ac, br, bc;
      ra = effective_dim(rows_a_raw);
      ca = effective_dim(cols_a_raw);
      rb = effective_dim(rows_b_raw);
      cb = effective_dim(cols_b_raw);
      if (it.kind != KIND_READ || it.row >= ra * rb || it.col >= ca * cb) begin
         return it;
      end
      ar = it.row / rb;
      ac = it.col / cb;
      br = it.row % rb;
      bc = it.col % cb;
      if (!a_written[ar * MAX_DIM + ac]) begin
         it.kind  = KIND_WRITE_A;
         it.row   = ROW_W'(ar);
         it.col   = ROW_W'(ac);
         it.value = rand_value();
      end else if (!b_written[br * MAX_DIM + bc]) begin
         it.kind  = KIND_WRITE_B;
         it.row   = ROW_W'(br);
         it.col   = ROW_W'(bc);
         it.value = rand_value();
      end
      return it;
   endfunction

   function automatic kpe_req_type make_item();
      kpe_req_type it;
      int unsigned ra, ca, rb, cb, roll;
      ra = effective_dim(rows_a_raw);
      ca = effective_dim(cols_a_raw);
      rb = effective_dim(rows_b_raw);
      cb = effective_dim(cols_b_raw);
      roll     = $urandom_range(0, 99);
      it.value = rand_value();
      if (roll < 45) begin
         it.kind = KIND_READ;
         it.row  = ROW_W'($urandom_range(0, ra * rb - 1));
         it.col  = ROW_W'($urandom_range(0, ca * cb - 1));
      end else if (roll < 75) begin
         if ($urandom_range(0, 1) == 0) begin
            it.kind = KIND_WRITE_A;
            it.row  = ROW_W'($urandom_range(0, ra - 1));
            it.col  = ROW_W'($urandom_range(0, ca - 1));
         end else begin
            it.kind = KIND_WRITE_B;
            it.row  = ROW_W'($urandom_range(0, rb - 1));
            it.col  = ROW_W'($urandom_range(0, cb - 1));
         end
      end else begin
         // Noise: any kind, each index either at most 20 or anywhere in its range.
         it.kind = KIND_W'($urandom_range(0, 3));
         it.row  = ROW_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 20));
         it.col  = ROW_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 20));
      end
      return fill_before_read(it);
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      if ($urandom_range(0, 4) == 0) begin
         return DIM_W'($urandom_range(0, 31));
      end
      return DIM_W'($urandom_range(1, 6));
   endfunction

   task automatic wait_drained();
      while (expected_elements.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                             input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
      kpe_csr_type      regs [4];
      logic [DIM_W-1:0] vals [4];
      regs = '{CSR_ROWS_A, CSR_COLS_A, CSR_ROWS_B, CSR_COLS_B};
      vals = '{ra, ca, rb, cb};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) begin
            @(posedge clock);
         end
         set_dim(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one item, records its expected result on transfer, then maybe idles.
   task automatic transfer_item(input kpe_req_type item, input logic typed,
                                input kpe_rsp_type typed_rsp);
      kpe_rsp_type predicted;
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = predict_element(item);
      expected_elements.push_back(typed ? typed_rsp : predicted);
      if (!no_idle && $urandom_range(0, 2) == 0) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result side: checks each transfer and stalls at random.
   initial begin
      kpe_rsp_type want;
      int unsigned stall_left;
      stall_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_elements.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected result: product %h status %b",
                           rsp_data.product, rsp_data.status);
               end
            end else begin
               want = expected_elements.pop_front();
               if (rsp_data.product !== want.product || rsp_data.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch: product exp %h got %h, status exp %b got %b",
                              want.product, rsp_data.product, want.status, rsp_data.status);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // Ends the run when no channel moves for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      wait (reset === 1'b0);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      kpe_rsp_type typed_rsp;
      kpe_req_type item;
      logic [DIM_W-1:0] dims [4];

      // Every dimension is one after reset, so only element (0,0) is in range.
      directed_rows = '{
         '{KIND_WRITE_A, 8'd0,   8'd0,   16'h8000, 1'b1, 32'h0000_0000, STATUS_OK},
         '{KIND_WRITE_B, 8'd0,   8'd0,   16'h8000, 1'b1, 32'h0000_0000, STATUS_OK},
         '{KIND_READ,    8'd0,   8'd0,   16'h0000, 1'b1, 32'h4000_0000, STATUS_OK},
         '{KIND_WRITE_A, 8'd0,   8'd0,   16'h7FFF, 1'b1, 32'h0000_0000, STATUS_OK},
         '{KIND_READ,    8'd0,   8'd0,   16'hFFFF, 1'b1, 32'hC000_8000, STATUS_OK},
         '{KIND_WRITE_B, 8'd0,   8'd0,   16'h7FFF, 1'b1, 32'h0000_0000, STATUS_OK},
         '{KIND_READ,    8'd0,   8'd0,   16'h0000, 1'b1, 32'h3FFF_0001, STATUS_OK},
         '{KIND_WRITE_A, 8'd0,   8'd0,   16'hFFFF, 1'b0, 32'h0000_0000, STATUS_OK},
         '{KIND_READ,    8'd0,   8'd0,   16'h0000, 1'b0, 32'h0000_0000, STATUS_OK},
         '{KIND_WRITE_A, 8'd0,   8'd0,   16'h0000, 1'b0, 32'h0000_0000, STATUS_OK},
         '{KIND_READ,    8'd0,   8'd0,   16'h5A5A, 1'b0, 32'h0000_0000, STATUS_OK},
         '{KIND_WRITE_A, 8'd1,   8'd0,   16'h1234, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_WRITE_A, 8'd0,   8'd1,   16'h1234, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_WRITE_B, 8'd255, 8'd255, 16'hFFFF, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_WRITE_B, 8'd0,   8'd128, 16'h0001, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_READ,    8'd1,   8'd0,   16'h0000, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_READ,    8'd0,   8'd1,   16'h0000, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_READ,    8'd255, 8'd255, 16'h0000, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_UNUSED,  8'd0,   8'd0,   16'hFFFF, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_UNUSED,  8'd255, 8'd255, 16'h0000, 1'b1, 32'h0000_0000, STATUS_RANGE_ERR},
         '{KIND_WRITE_A, 8'd0,   8'd0,   16'h0100, 1'b0, 32'h0000_0000, STATUS_OK},
         '{KIND_READ,    8'd0,   8'd0,   16'h0000, 1'b0, 32'h0000_0000, STATUS_OK}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item.kind         = directed_rows[i].kind;
         item.row          = directed_rows[i].row;
         item.col          = directed_rows[i].col;
         item.value        = directed_rows[i].value;
         typed_rsp.product = directed_rows[i].product;
         typed_rsp.status  = directed_rows[i].status;
         transfer_item(item, directed_rows[i].typed, typed_rsp);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: dims = '{5'd16, 5'd16, 5'd16, 5'd16};
            1: dims = '{5'd0, 5'd31, 5'd17, 5'd1};
            2: dims = '{5'd2, 5'd3, 5'd3, 5'd2};
            3: dims = '{5'd16, 5'd1, 5'd1, 5'd16};
            default: dims = '{rand_dim(), rand_dim(), rand_dim(), rand_dim()};
         endcase
         write_dims(dims[0], dims[1], dims[2], dims[3]);
         // One phase runs with no idling on either side.
         no_idle = (p == 3);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 2 && i == ITEMS_PER_PHASE / 2) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            item = make_item();
            typed_rsp = '0;
            transfer_item(item, 1'b0, typed_rsp);
         end
         req_valid <= 1'b0;
         no_idle = 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_elements.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
